FILE: rtl/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and codes for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned CpW   = 21;
  localparam int unsigned KindW = 2;
  localparam int unsigned RqDepth = 4;
  localparam int unsigned RqPtrW  = $clog2(RqDepth);
  localparam int unsigned RqCntW  = $clog2(RqDepth + 1);

  localparam logic [KindW-1:0] KIND_CHAR  = 2'd0;
  localparam logic [KindW-1:0] KIND_ERROR = 2'd1;
  localparam logic [KindW-1:0] KIND_END   = 2'd2;

  localparam logic [CpW-1:0] CP_LIMIT = 21'h110000;

  typedef struct packed {
    logic [CpW-1:0]   code_point;
    logic [KindW-1:0] kind;
    logic             last_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

FILE: rtl/utf8d_core.sv
// ----------------------------------------------------------------------------
// utf8d_core
// Input byte register, decoder state and single-pass decode of one byte into
// zero, one or two results.
// ----------------------------------------------------------------------------
module utf8d_core import utf8d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       room_i,
  output push_t      push_o
);

  logic           vld_q;
  logic [7:0]     byte_q;
  logic [1:0]     owed_q, owed_d;
  logic [CpW-1:0] part_q, part_d;
  logic           skip_q, skip_d;
  logic           fire;
  logic           is_cont;
  logic [CpW-1:0] part_shift;
  logic [1:0]     owed_dec;

  logic           lead_has;
  res_t           lead_res;
  logic [1:0]     lead_owed;
  logic [CpW-1:0] lead_part;
  logic           lead_skip;
  res_t           err_res;

  assign fire       = vld_q && room_i;
  assign in_ready_o = !vld_q || fire;
  assign is_cont    = (byte_q[7:6] == 2'b10);
  assign part_shift = {part_q[CpW-7:0], byte_q[5:0]};
  assign owed_dec   = owed_q - 2'd1;

  assign err_res = '{code_point: '0, kind: KIND_ERROR, last_of_run: 1'b1};

  always_comb begin
    lead_has  = 1'b0;
    lead_res  = err_res;
    lead_owed = 2'd0;
    lead_part = '0;
    lead_skip = 1'b0;
    if (byte_q < 8'h80) begin
      lead_has = 1'b1;
      if (byte_q == 8'h00) begin
        lead_res.kind = KIND_END;
      end else begin
        lead_res.kind       = KIND_CHAR;
        lead_res.code_point = CpW'(byte_q);
      end
    end else if (byte_q < 8'hC0) begin
      lead_has  = 1'b1;
      lead_skip = 1'b1;
    end else if (byte_q < 8'hE0) begin
      lead_owed = 2'd1;
      lead_part = CpW'(byte_q & 8'h1F);
    end else if (byte_q < 8'hF0) begin
      lead_owed = 2'd2;
      lead_part = CpW'(byte_q & 8'h0F);
    end else if (byte_q < 8'hF8) begin
      lead_owed = 2'd3;
      lead_part = CpW'(byte_q & 8'h07);
    end else begin
      lead_has = 1'b1;
    end
  end

  always_comb begin
    owed_d      = owed_q;
    part_d      = part_q;
    skip_d      = skip_q;
    push_o.num  = 2'd0;
    push_o.r0   = err_res;
    push_o.r1   = lead_res;
    if (skip_q && is_cont) begin
      // drop continuation bytes after a stray one
    end else if (owed_q != 2'd0 && is_cont) begin
      skip_d = 1'b0;
      owed_d = owed_dec;
      if (owed_dec == 2'd0) begin
        part_d     = '0;
        push_o.num = 2'd1;
        if (part_shift < CP_LIMIT) begin
          push_o.r0.kind       = KIND_CHAR;
          push_o.r0.code_point = part_shift;
        end
      end else begin
        part_d = part_shift;
      end
    end else if (owed_q != 2'd0) begin
      skip_d                = lead_skip;
      owed_d                = lead_owed;
      part_d                = lead_part;
      push_o.r0.last_of_run = !lead_has;
      push_o.num            = lead_has ? 2'd2 : 2'd1;
    end else begin
      skip_d     = lead_skip;
      owed_d     = lead_owed;
      part_d     = lead_part;
      push_o.r0  = lead_res;
      push_o.num = lead_has ? 2'd1 : 2'd0;
    end
    if (!fire) begin
      push_o.num = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      owed_q <= 2'd0;
      part_q <= '0;
      skip_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        vld_q <= 1'b1;
      end else if (fire) begin
        vld_q <= 1'b0;
      end
      if (fire) begin
        owed_q <= owed_d;
        part_q <= part_d;
        skip_q <= skip_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

endmodule

FILE: rtl/utf8d_rq.sv
// ----------------------------------------------------------------------------
// utf8d_rq
// Result queue: takes up to two results per cycle while it has room, hands out one per cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
module utf8d_rq import utf8d_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  push_t            push_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CpW-1:0]   code_point_o,
  output logic [KindW-1:0] kind_o,
  output logic             last_of_run_o
);

  res_t              mem_q [RqDepth];
  logic [RqPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [RqCntW-1:0] cnt_q;
  logic              pop;
  logic [RqPtrW-1:0] wr_ptr_nx;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign room_o      = (cnt_q <= RqCntW'(RqDepth - 2));
  assign wr_ptr_nx   = wr_ptr_q + RqPtrW'(1);

  assign code_point_o  = mem_q[rd_ptr_q].code_point;
  assign kind_o        = mem_q[rd_ptr_q].kind;
  assign last_of_run_o = mem_q[rd_ptr_q].last_of_run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + RqPtrW'(push_i.num);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + RqPtrW'(1);
      end
      cnt_q <= cnt_q + RqCntW'(push_i.num) - RqCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.r1;
    end
  end

endmodule

FILE: rtl/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 decoder, one byte per item, results as code points,
// errors and end-of-text markers.
// ----------------------------------------------------------------------------
// The decoder takes one byte per cycle while the queue has room and gives
// one result per cycle while out_ready_i is high. A byte is registered on
// entry and decoded into the result queue once it has room. A byte
// that ends a broken sequence and also decodes as a lead with a result
// yields two results, which leave one at a time; a four-entry result queue
// absorbs this, and input stalls only while it holds more than two results.
module utf8_stream_decoder import utf8d_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CpW-1:0]   code_point_o,
  output logic [KindW-1:0] kind_o,
  output logic             last_of_run_o
);

  push_t push;
  logic  room;

  utf8d_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .room_i     (room),
    .push_o     (push)
  );

  utf8d_rq u_rq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .room_o        (room),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .code_point_o  (code_point_o),
    .kind_o        (kind_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

FILE: rtl/utf8d_checker.sv
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks on the result channel of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
module utf8d_checker import utf8d_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [CpW-1:0]   code_point_o,
  input logic [KindW-1:0] kind_o,
  input logic             last_of_run_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("out_valid_o dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(code_point_o) && $stable(kind_o) && $stable(last_of_run_o))
    else $error("result changed while stalled");

  a_cp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_CHAR |-> code_point_o == '0)
    else $error("nonzero code point on a non-character result");

  a_only_err_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_ERROR |-> last_of_run_o)
    else $error("non-error result not last of its run");

  a_cp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_CHAR |-> code_point_o < CP_LIMIT)
    else $error("code point out of range");

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (.*);
